// ===== rtl/ric_pkg.sv =====
// Package with shared types and constants of the reprojection inlier counter.
`default_nettype none
package ric_pkg;
  localparam int unsigned CountWidth = 21;
  localparam int unsigned MatEntries = 12;
  localparam logic        CmdLoad    = 1'b0;
  localparam logic        CmdPoint   = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [3:0]            entry_index;
    logic signed [31:0]    entry_value;
    logic signed [31:0]    world_x;
    logic signed [31:0]    world_y;
    logic signed [31:0]    world_z;
    logic signed [31:0]    image_x;
    logic signed [31:0]    image_y;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic                  is_inlier;
    logic                  depth_zero;
    logic [CountWidth-1:0] inlier_count;
    logic                  batch_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;   // latch the accepted item
    logic       load;      // write a matrix entry
    logic       acc_clear; // clear projection accumulator
    logic       acc_step;  // add one product term
    logic [1:0] row;       // row being projected
    logic [1:0] col;       // column being multiplied
    logic       row_done;  // store saturated row sum
    logic       sq_step;   // one squared-distance step
    logic [2:0] sq_phase;
    logic       finish;    // compare and count
  } dp_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/ric_if.sv =====
// Valid/ready stream interfaces of the reprojection inlier counter.
`default_nettype none
interface ric_in_if;
  logic              valid;
  logic              ready;
  ric_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ric_out_if;
  logic               valid;
  logic               ready;
  ric_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ric_datapath.sv =====
// Datapath: matrix store, shared multiplier, distance test and inlier count.
`default_nettype none
module ric_datapath #(
  parameter int unsigned CountCap = 1048576
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire ric_pkg::in_item_t  item,
  input  wire ric_pkg::dp_cmd_t   cmd,
  input  wire [31:0]              threshold,
  output ric_pkg::out_item_t      result
);
  logic signed [31:0] mat [ric_pkg::MatEntries];
  ric_pkg::in_item_t  cur;
  logic signed [35:0] acc;
  logic signed [31:0] prow [3];
  logic signed [63:0] d0, d1;
  logic [63:0]        tp;
  logic [127:0]       sum_sq, thr_sq;
  logic [ric_pkg::CountWidth-1:0] count;

  // Shared 32x32 signed multiplier for the projection.
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [3:0]         midx;
  logic signed [35:0] term, sum_next;

  assign midx = 4'(cmd.row) * 4'd4 + 4'(cmd.col);
  always_comb begin
    ma = mat[midx];
    case (cmd.col)
      2'd0:    mb = cur.world_x;
      2'd1:    mb = cur.world_y;
      2'd2:    mb = cur.world_z;
      default: mb = 32'sd0;
    endcase
    prod = ma * mb;
    if (cmd.col == 2'd3) term = 36'(ma >>> 14);
    else term = 36'(prod >>> 30);
    sum_next = acc + term;
  end

  // Each 64-bit magnitude is squared from 32x32 partial products: high by
  // high with low by low first, then the doubled cross term.
  logic [63:0] mg;
  logic [31:0] pa, pb;
  logic [63:0] pp, lo_pp;
  logic [127:0] pp_sh, lo_sq;
  always_comb begin
    case (cmd.sq_phase)
      3'd1, 3'd2: mg = d0[63] ? 64'(-d0) : 64'(d0);
      3'd3, 3'd4: mg = d1[63] ? 64'(-d1) : 64'(d1);
      default:    mg = tp;
    endcase
    pa = cmd.sq_phase[0] ? mg[63:32] : mg[31:0];
    pb = mg[63:32];
    pp = 64'(pa) * 64'(pb);
    lo_pp = 64'(mg[31:0]) * 64'(mg[31:0]);
    lo_sq = {64'd0, lo_pp};
    pp_sh = cmd.sq_phase[0] ? {pp, 64'd0} : {31'd0, pp, 33'd0};
  end

  logic signed [31:0] p2;
  logic [63:0] p2mag;
  assign p2 = prow[2];
  assign p2mag = p2[31] ? 64'(-64'(p2)) : 64'(p2);

  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= item;
    if (rst) mat <= '{default: '0};
    else if (cmd.load && item.entry_index < 4'(ric_pkg::MatEntries))
      mat[item.entry_index] <= item.entry_value;
    if (cmd.acc_clear) acc <= '0;
    else if (cmd.acc_step) acc <= sum_next;
    if (cmd.row_done) begin
      if (sum_next > 36'sd2147483647) prow[cmd.row] <= 32'sh7fffffff;
      else if (sum_next < -36'sd2147483648) prow[cmd.row] <= 32'sh80000000;
      else prow[cmd.row] <= 32'(sum_next);
    end
    if (cmd.sq_step) begin
      case (cmd.sq_phase)
        3'd0: begin
          d0 <= {{16{prow[0][31]}}, prow[0], 16'd0} - 64'(cur.image_x) * 64'(p2);
          d1 <= {{16{prow[1][31]}}, prow[1], 16'd0} - 64'(cur.image_y) * 64'(p2);
          tp <= 64'(threshold) * p2mag;
          sum_sq <= '0;
        end
        3'd1: sum_sq <= sum_sq + lo_sq + pp_sh;
        3'd2: sum_sq <= sum_sq + pp_sh;
        3'd3: sum_sq <= sum_sq + lo_sq + pp_sh;
        3'd4: sum_sq <= sum_sq + pp_sh;
        3'd5: thr_sq <= lo_sq + pp_sh;
        3'd6: thr_sq <= thr_sq + pp_sh;
        default: ;
      endcase
    end
  end

  logic inl, zero;
  assign zero = (p2 == 32'sd0);
  assign inl = !zero && (sum_sq < thr_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      if (cur.last) count <= '0;
      else if (inl && count < ric_pkg::CountWidth'(CountCap)) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.is_inlier <= inl;
      result.depth_zero <= zero;
      result.batch_end <= cur.last;
      result.inlier_count <= (inl && count < ric_pkg::CountWidth'(CountCap))
                             ? count + 1'b1 : count;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ric_control.sv =====
// Controller: sequences one item through the datapath and drives the handshakes.
`default_nettype none
module ric_control (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output ric_pkg::dp_cmd_t      cmd
);
  typedef enum logic [1:0] {IDLE, PROJ, SQ, DONE} state_t;
  state_t state;
  logic [1:0] row, col;
  logic [2:0] phase;
  logic       accept, out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.capture  = accept;
    cmd.load     = accept && in_cmd == ric_pkg::CmdLoad;
    cmd.acc_clear = accept || (state == PROJ && col == 2'd3);
    cmd.acc_step = (state == PROJ);
    cmd.row      = row;
    cmd.col      = col;
    cmd.row_done = (state == PROJ && col == 2'd3);
    cmd.sq_step  = (state == SQ);
    cmd.sq_phase = phase;
    cmd.finish   = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; row <= '0; col <= '0; phase <= '0; out_valid <= 1'b0;
    end else begin
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (accept && in_cmd == ric_pkg::CmdPoint) begin
          state <= PROJ; row <= '0; col <= '0;
        end
        PROJ: begin
          col <= col + 1'b1;
          if (col == 2'd3) begin
            row <= row + 1'b1;
            if (row == 2'd2) begin
              state <= SQ; phase <= '0;
            end
          end
        end
        SQ: begin
          phase <= phase + 1'b1;
          if (phase == 3'd6) state <= DONE;
        end
        DONE: if (out_free) begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> !in_ready) else $error("ready while busy");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == DONE) else $error("result outside done");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

// ===== rtl/reprojection_inlier_counter.sv =====
// Top level of the reprojection inlier counter.
// Usage: items arrive on in_ch (valid/ready); a transfer with cmd 0 writes
// one matrix entry (indices past 11 are dropped) and yields no result, so
// loads can follow one another without a gap. A transfer with cmd 1 projects
// the world point through the stored 3x4 matrix, one term per cycle on one
// shared multiplier, then forms the image-plane differences and the squared
// distance and squared threshold terms from 32x32 partial products, and in
// its final state places the result in the output register of out_ch.
// A point is taken only while the block is idle, so the next transfer waits
// until the previous point's result has been placed in the output register.
// The result register holds its item while the receiver stalls; the block
// waits in its final state until that register is free, with in_ch.ready
// low meanwhile.
// Reset clears the controller, the matrix and the inlier count and sets the
// threshold to 1.0; in_ch.ready stays low while reset is held.
// The threshold is written through cfg_we/cfg_data while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
`default_nettype none
module reprojection_inlier_counter #(
  parameter int unsigned MAX_POINTS = 1048576
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire [31:0]   cfg_data,
  ric_in_if.sink       in_ch,
  ric_out_if.source    out_ch
);
  localparam int unsigned CountCap =
      (MAX_POINTS < 2097151) ? MAX_POINTS : 2097151;

  logic [31:0]       distance_threshold;
  ric_pkg::dp_cmd_t  cmd;

  always_ff @(posedge clk) begin
    if (rst) distance_threshold <= 32'd65536;
    else if (cfg_we) distance_threshold <= cfg_data;
  end

  ric_control u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_cmd (in_ch.data.cmd), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .cmd (cmd)
  );

  ric_datapath #(.CountCap(CountCap)) u_dp (
    .clk, .rst, .item (in_ch.data), .cmd (cmd),
    .threshold (distance_threshold), .result (out_ch.data)
  );
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the reprojection inlier counter.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  // Idle time after the last result, long enough for the block to settle
  // before the threshold is rewritten.
  localparam int SettleCycles = 40;
  localparam int CycleLimit   = 2000000;
  localparam int MaxPoints    = 1048576;
  localparam int PhaseItems   = 270;
  localparam int LongHold     = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  ric_in_if  in_ch ();
  ric_out_if out_ch ();

  reprojection_inlier_counter #(.MAX_POINTS(MaxPoints)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's state, kept by the scorer below.
  logic signed [31:0] shadow_matrix [12];
  logic [20:0]        shadow_count;
  logic [31:0]        shadow_threshold;

  ric_pkg::out_item_t pending_results [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  logic      in_fire = 1'b0;
  logic      calm = 1'b0;
  logic      hold_req = 1'b0;

  // A directed row may carry a result typed in by hand; when set, it is
  // queued in place of the scorer's own answer.
  logic      fixed_valid = 1'b0;
  ric_pkg::out_item_t fixed_result;

  // One row of the projection with the floor shifts and saturation the
  // hardware uses. Each product fits comfortably into 64 bits.
  function automatic logic signed [31:0] project_row(int row, logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z);
    longint acc;
    acc = ((longint'(shadow_matrix[row*4])   * longint'(x)) >>> 30)
        + ((longint'(shadow_matrix[row*4+1]) * longint'(y)) >>> 30)
        + ((longint'(shadow_matrix[row*4+2]) * longint'(z)) >>> 30)
        + (longint'(shadow_matrix[row*4+3]) >>> 14);
    if (acc > 64'sd2147483647) return 32'sh7fffffff;
    if (acc < -64'sd2147483648) return 32'sh80000000;
    return acc[31:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Applies one accepted transfer to the shadow state. Returns 1 and fills
  // res for a point; a load yields nothing.
  function automatic bit score_transfer(ric_pkg::in_item_t it,
                                        output ric_pkg::out_item_t res);
    logic signed [31:0] p0, p1, p2;
    longint             d0, d1;
    logic [63:0]        m0, m1, tp;
    logic [128:0]       dist_sq, limit_sq;
    logic               hit;
    res = '0;
    if (it.cmd == ric_pkg::CmdLoad) begin
      if (it.entry_index < ric_pkg::MatEntries)
        shadow_matrix[it.entry_index] = it.entry_value;
      return 1'b0;
    end
    p0 = project_row(0, it.world_x, it.world_y, it.world_z);
    p1 = project_row(1, it.world_x, it.world_y, it.world_z);
    p2 = project_row(2, it.world_x, it.world_y, it.world_z);
    hit = 1'b0;
    if (p2 != 0) begin
      d0 = longint'(p0) * 65536 - longint'(it.image_x) * longint'(p2);
      d1 = longint'(p1) * 65536 - longint'(it.image_y) * longint'(p2);
      m0 = magnitude(d0);
      m1 = magnitude(d1);
      dist_sq = 129'({64'b0, m0} * {64'b0, m0}) + 129'({64'b0, m1} * {64'b0, m1});
      tp = 64'(shadow_threshold) * magnitude(longint'(p2));
      limit_sq = 129'({64'b0, tp} * {64'b0, tp});
      hit = dist_sq < limit_sq;
    end
    if (hit && shadow_count < MaxPoints) shadow_count = shadow_count + 1;
    res.is_inlier    = hit;
    res.depth_zero   = (p2 == 0);
    res.inlier_count = shadow_count;
    res.batch_end    = it.last;
    if (it.last) shadow_count = '0;
    return 1'b1;
  endfunction

  // Input side: every accepted transfer goes through the scorer straight away.
  always @(posedge clk) begin
    ric_pkg::out_item_t res;
    cycle_count <= cycle_count + 1;
    in_fire <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    if ((in_ch.valid === 1'b1) && (in_ch.ready === 1'b1)) begin
      if (score_transfer(in_ch.data, res)) begin
        if (fixed_valid) res = fixed_result;
        pending_results = {pending_results, res};
      end
    end
  end

  // Output side: each delivered result is matched against the oldest one due.
  always @(posedge clk) begin
    ric_pkg::out_item_t want;
    if ((out_ch.valid === 1'b1) && (out_ch.ready === 1'b1)) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_ch.data);
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data.is_inlier !== want.is_inlier) begin
          $error("is_inlier expected %0d got %0d", want.is_inlier, out_ch.data.is_inlier);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.depth_zero !== want.depth_zero) begin
          $error("depth_zero expected %0d got %0d", want.depth_zero,
                 out_ch.data.depth_zero);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.inlier_count !== want.inlier_count) begin
          $error("inlier_count expected %0d got %0d", want.inlier_count,
                 out_ch.data.inlier_count);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.batch_end !== want.batch_end) begin
          $error("batch_end expected %0d got %0d", want.batch_end, out_ch.data.batch_end);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog: a hung handshake must not keep the simulation alive for ever.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request so that
  // the result register stays full and the block stops taking transfers.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req <= 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic ric_pkg::in_item_t load_item(int idx, logic signed [31:0] val,
                                                  logic lst = 1'b0);
    ric_pkg::in_item_t it;
    it = '0;
    it.cmd         = ric_pkg::CmdLoad;
    it.entry_index = 4'(idx);
    it.entry_value = val;
    it.last        = lst;
    return it;
  endfunction

  function automatic ric_pkg::in_item_t point_item(logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z,
                                                   logic signed [31:0] ix,
                                                   logic signed [31:0] iy, logic lst);
    ric_pkg::in_item_t it;
    it = '0;
    it.cmd     = ric_pkg::CmdPoint;
    it.world_x = x;
    it.world_y = y;
    it.world_z = z;
    it.image_x = ix;
    it.image_y = iy;
    it.last    = lst;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_signed(int lo, int hi);
    return 32'($signed($urandom_range(0, hi - lo)) + lo);
  endfunction

  // A matrix that resembles a real camera: near unit scale on the diagonal,
  // small skew and a depth row close to 1.0, so that projections stay sane.
  function automatic ric_pkg::in_item_t camera_entry(int idx);
    logic signed [31:0] val;
    case (idx)
      0, 5:    val = rand_signed(32'h2000_0000, 32'h6000_0000);
      11:      val = rand_signed(32'h3c00_0000, 32'h4400_0000);
      10:      val = rand_signed(-32'h0080_0000, 32'h0080_0000);
      default: val = rand_signed(-32'h0400_0000, 32'h0400_0000);
    endcase
    return load_item(idx, val);
  endfunction

  // Some picks are matrix loads; most points are placed near their true
  // projection so that both verdicts occur, the rest carry raw random bits.
  function automatic ric_pkg::in_item_t random_item();
    ric_pkg::in_item_t  it;
    logic signed [31:0] x, y, z, p0, p1, p2;
    longint             ix, iy;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return camera_entry($urandom_range(0, 11));
    if (pick < 12) return load_item($urandom_range(0, 15), $urandom,
                                    1'($urandom_range(0, 1)));
    if (pick < 20) begin
      it = '0;
      it.cmd         = ric_pkg::CmdPoint;
      it.entry_index = 4'($urandom);
      it.entry_value = $urandom;
      it.world_x     = $urandom;
      it.world_y     = $urandom;
      it.world_z     = $urandom;
      it.image_x     = $urandom;
      it.image_y     = $urandom;
      it.last        = ($urandom_range(0, 19) == 0);
      return it;
    end
    x = rand_signed(-32'h0064_0000, 32'h0064_0000);
    y = rand_signed(-32'h0064_0000, 32'h0064_0000);
    z = rand_signed(-32'h0064_0000, 32'h0064_0000);
    p0 = project_row(0, x, y, z);
    p1 = project_row(1, x, y, z);
    p2 = project_row(2, x, y, z);
    if (p2 == 0) begin
      ix = $urandom;
      iy = $urandom;
    end else begin
      ix = longint'(p0) * 65536 / longint'(p2)
         + longint'($urandom_range(0, 6 << 16)) - (3 << 16);
      iy = longint'(p1) * 65536 / longint'(p2)
         + longint'($urandom_range(0, 6 << 16)) - (3 << 16);
    end
    return point_item(x, y, z, 32'(ix), 32'(iy), $urandom_range(0, 19) == 0);
  endfunction

  // Offers one item and returns at the falling edge after its transfer, with
  // valid still high so that a following item can follow without a gap.
  task automatic offer(ric_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Waits until every result due has arrived and the block has gone quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_threshold = val;
  endtask

  typedef struct {
    ric_pkg::in_item_t  item;
    bit                 fixed;
    ric_pkg::out_item_t result;
  } directed_row_t;

  directed_row_t directed [$];

  task automatic add_row(ric_pkg::in_item_t it, bit fixed = 1'b0,
                         ric_pkg::out_item_t res = '0);
    directed_row_t r;
    r.item   = it;
    r.fixed  = fixed;
    r.result = res;
    directed = {directed, r};
  endtask

  initial begin
    logic [31:0] phase_thresholds [6];
    foreach (shadow_matrix[i]) shadow_matrix[i] = '0;
    shadow_count     = '0;
    shadow_threshold = 32'h0001_0000;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;

    // Directed part. With an all-zero matrix every depth is zero.
    add_row(point_item(0, 0, 0, 0, 0, 1'b0), 1'b1, '{0, 1, 0, 0});
    add_row(point_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       32'sh7fffffff, 32'sh7fffffff, 1'b1), 1'b1, '{0, 1, 0, 1});
    // Loads past the last entry are dropped, and a load's last flag means nothing.
    add_row(load_item(12, 32'sh7fffffff));
    add_row(load_item(15, 32'sh80000000, 1'b1));
    // Unit camera: p0 = x, p1 = y, p2 = 1.0.
    add_row(load_item(0, 32'sh4000_0000));
    add_row(load_item(5, 32'sh4000_0000));
    add_row(load_item(11, 32'sh4000_0000));
    add_row(point_item(0, 0, 0, 0, 0, 1'b0), 1'b1, '{1, 0, 1, 0});
    add_row(point_item(32'sh2_0000, 0, 0, 32'sh2_8000, 0, 1'b0));
    // Exactly one pixel away is not strictly inside the threshold.
    add_row(point_item(0, 0, 0, 32'sh1_0000, 0, 1'b1), 1'b1, '{0, 0, 2, 1});
    add_row(point_item(0, 0, 0, 0, 32'sh0_ffff, 1'b0));
    add_row(load_item(10, 32'sh80000000));
    add_row(load_item(3, 32'sh7fffffff));
    add_row(point_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 1'b0));
    add_row(point_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                       32'sh80000000, 32'sh7fffffff, 1'b0));
    add_row(load_item(1, 32'sh7fffffff));
    add_row(load_item(9, 32'sh80000000));
    add_row(point_item(32'sh0001_0000, 32'sh7fffffff, 32'sh0000_4000,
                       32'sh7fffffff, 32'sh80000000, 1'b0));
    // A depth that cancels to zero: -2.0 * 0.5 + 1.0.
    add_row(load_item(9, 32'sh0));
    add_row(point_item(0, 0, 32'sh0000_8000, 0, 0, 1'b1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      sender_gap();
      fixed_valid  <= directed[i].fixed;
      fixed_result <= directed[i].result;
      offer(directed[i].item);
    end
    fixed_valid <= 1'b0;
    drain();

    // Random part: the threshold swept through its extremes and typical
    // values, the last phase without any idling on either side.
    phase_thresholds = '{32'h0, 32'hffff_ffff, 32'h0002_0000, $urandom,
                         32'h0000_8000, 32'h0001_8000};
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(phase_thresholds[ph]);
      for (int k = 0; k < 12; k++) offer(camera_entry(k));
      calm = (ph == 5);
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 2 && n == 100) hold_req <= 1'b1;
        sender_gap();
        offer(random_item());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
